// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files of the date unit.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion of a whole property, disabled during reset.
`define GDA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("date unit assertion failed");

// Concurrent same-cycle implication, disabled during reset.
`define GDA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date unit implication failed");

`endif

// ===== rtl/core/gda_pkg.sv =====
// Package of the Gregorian date add unit: field widths, month codes,
// month length and cumulative day tables. Depends on nothing.
package gda_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned ModW   = 9;  // holds year mod 400

  localparam logic [ModW-1:0] YearCycle = ModW'(400);

  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthMar = MonthW'(3);
  localparam logic [MonthW-1:0] MonthApr = MonthW'(4);
  localparam logic [MonthW-1:0] MonthJun = MonthW'(6);
  localparam logic [MonthW-1:0] MonthSep = MonthW'(9);
  localparam logic [MonthW-1:0] MonthNov = MonthW'(11);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);
  localparam logic [MonthW-1:0] MonthJan = MonthW'(1);

  // Leap year from the year taken mod 400 (4/100/400 rule).
  function automatic logic is_leap(input logic [ModW-1:0] ymod);
    return (ymod[1:0] == 2'd0) && (ymod != ModW'(100)) &&
           (ymod != ModW'(200)) && (ymod != ModW'(300));
  endfunction

  // Days in a month; out-of-range codes count 31 days.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      MonthFeb: len = leap ? DayW'(29) : DayW'(28);
      MonthApr, MonthJun, MonthSep, MonthNov: len = DayW'(30);
      default: len = DayW'(31);
    endcase
    return len;
  endfunction

  // Days of months 1..m-1 in a common year; codes past 12 add 31 each.
  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] acc;
    unique case (m)
      4'd0, 4'd1: acc = DoyW'(0);
      4'd2:       acc = DoyW'(31);
      4'd3:       acc = DoyW'(59);
      4'd4:       acc = DoyW'(90);
      4'd5:       acc = DoyW'(120);
      4'd6:       acc = DoyW'(151);
      4'd7:       acc = DoyW'(181);
      4'd8:       acc = DoyW'(212);
      4'd9:       acc = DoyW'(243);
      4'd10:      acc = DoyW'(273);
      4'd11:      acc = DoyW'(304);
      4'd12:      acc = DoyW'(334);
      4'd13:      acc = DoyW'(365);
      4'd14:      acc = DoyW'(396);
      default:    acc = DoyW'(427);
    endcase
    return acc;
  endfunction

endpackage

// ===== rtl/core/gda_if.sv =====
// Valid/ready channel interfaces of the date add unit (request and result).
// Depends on gda_pkg for the fixed field widths.
interface gda_in_if #(
  parameter int unsigned YEAR_BITS = 14,
  parameter int unsigned ADD_BITS  = 16
);
  logic                        valid;
  logic                        ready;
  logic [gda_pkg::DayW-1:0]    day;
  logic [gda_pkg::MonthW-1:0]  month;
  logic [YEAR_BITS-1:0]        year;
  logic [ADD_BITS-1:0]         days_to_add;
  logic [gda_pkg::DayW-1:0]    cmp_day;
  logic [gda_pkg::MonthW-1:0]  cmp_month;
  logic [YEAR_BITS-1:0]        cmp_year;

  modport source (output valid, day, month, year, days_to_add, cmp_day, cmp_month,
                  cmp_year, input ready);
  modport sink   (input valid, day, month, year, days_to_add, cmp_day, cmp_month,
                  cmp_year, output ready);
endinterface

interface gda_out_if #(
  parameter int unsigned YEAR_BITS = 14
);
  logic                        valid;
  logic                        ready;
  logic [gda_pkg::DayW-1:0]    res_day;
  logic [gda_pkg::MonthW-1:0]  res_month;
  logic [YEAR_BITS-1:0]        res_year;
  logic                        year_overflow;
  logic [gda_pkg::DoyW-1:0]    day_of_year;
  logic                        is_less;
  logic                        is_equal;

  modport source (output valid, res_day, res_month, res_year, year_overflow,
                  day_of_year, is_less, is_equal, input ready);
  modport sink   (input valid, res_day, res_month, res_year, year_overflow,
                  day_of_year, is_less, is_equal, output ready);
endinterface

// ===== rtl/core/gregorian_date_add_days_top.sv =====
// Sequence: the year is reduced mod 400 (reciprocal multiply in ST_DIV, then subtract in ST_REM),
// then ST_STEP crosses one month boundary per step and loads the result register once it is free.
// Flow: one transaction at a time; a new request is taken once the sequencer is idle, even while
// the previous result waits.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
// Depends on gda_pkg and the gda_in_if / gda_out_if interfaces.
module gregorian_date_add_days_top #(
  parameter int unsigned YEAR_BITS = 14,
  parameter int unsigned ADD_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gda_in_if.sink    in_i,
  gda_out_if.source out_o
);

  localparam int unsigned     LeftW    = ADD_BITS + gda_pkg::DayW + 1;
  localparam int unsigned     QuoShift = YEAR_BITS + gda_pkg::ModW;
  localparam int unsigned     ProdW    = 2 * YEAR_BITS + 1;
  localparam longint unsigned Divisor  = 64'(gda_pkg::YearCycle);
  // Rounded-up reciprocal of 400; exact quotient for every YEAR_BITS-wide year
  localparam longint unsigned QuoMult  = ((64'd1 << QuoShift) + Divisor - 64'd1) / Divisor;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_STEP
  } state_e;

  state_e                         state_q;
  logic [YEAR_BITS-1:0]           quo_q;
  logic [gda_pkg::ModW-1:0]       rem_q;
  logic [gda_pkg::DayW-1:0]       rd_q;
  logic [gda_pkg::MonthW-1:0]     rm_q;
  logic [YEAR_BITS-1:0]           ry_q;
  logic [ADD_BITS-1:0]            left_q;
  logic                           ovf_q;
  logic [gda_pkg::DayW-1:0]       base_day_q;
  logic [gda_pkg::MonthW-1:0]     base_month_q;
  logic                           base_leap_q;
  logic                           less_q;
  logic                           equal_q;

  logic                           out_valid_q;
  logic [gda_pkg::DayW-1:0]       res_day_q;
  logic [gda_pkg::MonthW-1:0]     res_month_q;
  logic [YEAR_BITS-1:0]           res_year_q;
  logic                           res_ovf_q;
  logic [gda_pkg::DoyW-1:0]       res_doy_q;
  logic                           res_less_q;
  logic                           res_equal_q;

  logic                           in_fire;
  logic                           out_free;
  logic                           res_load;
  logic [ProdW-1:0]               quo_prod;
  logic [YEAR_BITS-1:0]           quo_400;
  logic [gda_pkg::ModW-1:0]       rem_calc;
  logic [gda_pkg::DayW-1:0]       len;
  logic [gda_pkg::DayW-1:0]       room;
  logic                           in_month;
  logic                           fits;
  logic [LeftW-1:0]               used;
  logic [LeftW-1:0]               left_rest;
  logic                           done_now;
  logic [gda_pkg::DoyW-1:0]       doy;
  logic                           ymax;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Year mod 400: quotient by reciprocal multiply, then subtract 400 * quotient
  // (400 = 256 + 128 + 16, built from shifts).
  assign quo_prod = ProdW'(ry_q) * ProdW'(QuoMult);
  assign quo_400  = (quo_q << 8) + (quo_q << 7) + (quo_q << 4);
  assign rem_calc = gda_pkg::ModW'(ry_q - quo_400);

  // Month step: finish inside this month or consume up to the next month.
  always_comb begin
    len       = gda_pkg::month_len(rm_q, gda_pkg::is_leap(rem_q));
    room      = len - rd_q;
    in_month  = rd_q < len;
    fits      = in_month && (LeftW'(left_q) <= LeftW'(room));
    used      = in_month ? (LeftW'(room) + LeftW'(1)) : LeftW'(1);
    left_rest = LeftW'(left_q) - used;
    done_now  = (left_q == '0) || fits;
    ymax      = (ry_q == {YEAR_BITS{1'b1}});
  end

  assign res_load = (state_q == ST_STEP) && done_now && out_free;

  // Ordinal day of the base date.
  assign doy = gda_pkg::days_before(base_month_q) + gda_pkg::DoyW'(base_day_q) +
               gda_pkg::DoyW'(base_leap_q && (base_month_q >= gda_pkg::MonthMar));

  // Sequencer, working registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      quo_q        <= '0;
      rem_q        <= '0;
      rd_q         <= '0;
      rm_q         <= '0;
      ry_q         <= '0;
      left_q       <= '0;
      ovf_q        <= 1'b0;
      base_day_q   <= '0;
      base_month_q <= '0;
      base_leap_q  <= 1'b0;
      less_q       <= 1'b0;
      equal_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      res_day_q    <= '0;
      res_month_q  <= '0;
      res_year_q   <= '0;
      res_ovf_q    <= 1'b0;
      res_doy_q    <= '0;
      res_less_q   <= 1'b0;
      res_equal_q  <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once taken.
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            rem_q        <= '0;
            rd_q         <= in_i.day;
            rm_q         <= in_i.month;
            ry_q         <= in_i.year;
            left_q       <= in_i.days_to_add;
            ovf_q        <= 1'b0;
            base_day_q   <= in_i.day;
            base_month_q <= in_i.month;
            less_q       <= {in_i.year, in_i.month, in_i.day} <
                            {in_i.cmp_year, in_i.cmp_month, in_i.cmp_day};
            equal_q      <= {in_i.year, in_i.month, in_i.day} ==
                            {in_i.cmp_year, in_i.cmp_month, in_i.cmp_day};
            state_q      <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_q   <= YEAR_BITS'(quo_prod >> QuoShift);
          state_q <= ST_REM;
        end
        ST_REM: begin
          rem_q       <= rem_calc;
          base_leap_q <= gda_pkg::is_leap(rem_calc);
          state_q     <= ST_STEP;
        end
        ST_STEP: begin
          if (done_now) begin
            // Hold until the result register is free.
            if (out_free) begin
              res_day_q   <= fits ? (rd_q + gda_pkg::DayW'(left_q)) : rd_q;
              res_month_q <= rm_q;
              res_year_q  <= ry_q;
              res_ovf_q   <= ovf_q;
              res_doy_q   <= doy;
              res_less_q  <= less_q;
              res_equal_q <= equal_q;
              state_q     <= ST_IDLE;
            end
          end else begin
            // Advance to day 1 of the next month.
            left_q <= ADD_BITS'(left_rest);
            rd_q   <= gda_pkg::DayW'(1);
            if (rm_q >= gda_pkg::MonthDec) begin
              rm_q <= gda_pkg::MonthJan;
              if (ymax) begin
                ry_q  <= '0;
                rem_q <= '0;
                ovf_q <= 1'b1;
              end else begin
                ry_q  <= ry_q + YEAR_BITS'(1);
                rem_q <= (rem_q == gda_pkg::YearCycle - gda_pkg::ModW'(1)) ?
                         '0 : rem_q + gda_pkg::ModW'(1);
              end
            end else begin
              rm_q <= rm_q + gda_pkg::MonthW'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.res_day       = res_day_q;
  assign out_o.res_month     = res_month_q;
  assign out_o.res_year      = res_year_q;
  assign out_o.year_overflow = res_ovf_q;
  assign out_o.day_of_year   = res_doy_q;
  assign out_o.is_less       = res_less_q;
  assign out_o.is_equal      = res_equal_q;

endmodule

// ===== rtl/core/gda_checker.sv =====
// Port-level checker of the date add unit, bound to the top level.
// Depends on assert_macros.svh and the top level's channel ports.
`include "assert_macros.svh"

module gda_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic is_less_i,
  input logic is_equal_i,
  input logic year_overflow_i
);

  // A pending result holds until taken.
  `GDA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  // The overflow flag of a stalled result stays put.
  `GDA_ASSERT(a_ovf_stable, clk_i, rst_ni,
    out_valid_i && !out_ready_i |=> $stable(year_overflow_i))
  // One transaction at a time: the sequencer is busy right after an accept.
  `GDA_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i)
  // Equal and earlier never both hold.
  `GDA_ASSERT_IMPLY(a_order_excl, clk_i, rst_ni, out_valid_i && is_equal_i, !is_less_i)

endmodule

bind gregorian_date_add_days_top gda_checker u_gda_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .is_less_i      (out_o.is_less),
  .is_equal_i     (out_o.is_equal),
  .year_overflow_i(out_o.year_overflow)
);
